// ===== rtl/core/sauvola_pkg.sv =====
// sauvola_pkg: shared types and constants of the sauvola local threshold block
// used by sauvola_iter, the top, checker and testbench; depends on nothing
`default_nettype none

package sauvola_pkg;

   localparam int DIM_W = 11;

   localparam logic [7:0]  ROWS_RESET  = 8'd128;
   localparam logic [7:0]  COLS_RESET  = 8'd128;
   localparam logic [6:0]  WIN_RESET   = 7'd51;
   localparam logic [15:0] K_RESET     = 16'd22282;
   localparam logic [7:0]  RANGE_RESET = 8'd128;

   localparam logic [2:0] CSR_FRAME_ROWS    = 3'd0;
   localparam logic [2:0] CSR_FRAME_COLS    = 3'd1;
   localparam logic [2:0] CSR_WINDOW_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_K_Q16         = 3'd3;
   localparam logic [2:0] CSR_DYNAMIC_RANGE = 3'd4;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [7:0] PIX_BLACK = 8'd0;
   localparam logic [7:0] PIX_WHITE = 8'd255;

   localparam logic [5:0]  SQRT_STEPS    = 6'd24;
   localparam logic [5:0]  VAR_DIV_STEPS = 6'd48;
   localparam logic [47:0] SQRT_TOP_BIT  = 48'h4000_0000_0000;
   localparam logic [47:0] VAR_MAX       = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic       start;
      logic       sqrt;
      logic [5:0] steps;
   } iter_cmd_type;

   typedef enum logic [14:0] {
      ST_IDLE    = 15'b000000000000001,
      ST_L_DIV   = 15'b000000000000010,
      ST_L_READ  = 15'b000000000000100,
      ST_L_WRITE = 15'b000000000001000,
      ST_Q_BOUND = 15'b000000000010000,
      ST_Q_READ  = 15'b000000000100000,
      ST_Q_ACC   = 15'b000000001000000,
      ST_Q_MUL   = 15'b000000010000000,
      ST_Q_NUM   = 15'b000000100000000,
      ST_Q_OVF   = 15'b000001000000000,
      ST_Q_DIV   = 15'b000010000000000,
      ST_Q_SQS   = 15'b000100000000000,
      ST_Q_SQRT  = 15'b001000000000000,
      ST_Q_FIN   = 15'b010000000000000,
      ST_Q_CMP   = 15'b100000000000000
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/sauvola_ram.sv =====
// sauvola_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module sauvola_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sauvola_iter.sv =====
// sauvola_iter: shared shift-subtract unit, one restoring division or square root step a cycle
// depends on sauvola_pkg
`default_nettype none

module sauvola_iter (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sauvola_pkg::iter_cmd_type cmd,
   input  wire logic [27:0]               rem_init,
   input  wire logic [47:0]               dividend,
   input  wire logic [27:0]               divisor,
   input  wire logic [47:0]               radicand,
   output logic                           done,
   output logic [47:0]                    quotient,
   output logic [27:0]                    remainder,
   output logic [24:0]                    root
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        sqrt_ff, sqrt_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [47:0] acc_ff, acc_in;
   logic [47:0] res_ff, res_in;
   logic [47:0] dsr_ff, dsr_in;
   logic [27:0] dvs_ff, dvs_in;
   logic [48:0] op_a, op_b;
   logic [49:0] diff;
   logic        ge;

   always_comb begin
      op_a = sqrt_ff ? {1'b0, acc_ff} : {20'd0, acc_ff[27:0], dsr_ff[47]};
      op_b = sqrt_ff ? ({1'b0, res_ff} + {1'b0, dsr_ff}) : {21'd0, dvs_ff};
      diff = {1'b0, op_a} - {1'b0, op_b};
      ge   = ~diff[49];

      busy_in = busy_ff;
      done_in = 1'b0;
      sqrt_in = sqrt_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;
      dsr_in  = dsr_ff;
      dvs_in  = dvs_ff;

      if (cmd.start) begin
         busy_in = 1'b1;
         sqrt_in = cmd.sqrt;
         cnt_in  = cmd.steps;
         res_in  = '0;
         dvs_in  = divisor;
         if (cmd.sqrt) begin
            acc_in = radicand;
            dsr_in = sauvola_pkg::SQRT_TOP_BIT;
         end else begin
            acc_in = {20'd0, rem_init};
            dsr_in = dividend;
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (sqrt_ff) begin
            acc_in = ge ? diff[47:0] : acc_ff;
            res_in = ge ? ((res_ff >> 1) + dsr_ff) : (res_ff >> 1);
            dsr_in = dsr_ff >> 2;
         end else begin
            acc_in = ge ? diff[47:0] : op_a[47:0];
            res_in = {res_ff[46:0], ge};
            dsr_in = dsr_ff << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sqrt_ff <= sqrt_in;
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
      dsr_ff  <= dsr_in;
      dvs_ff  <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = res_ff;
   assign remainder = acc_ff[27:0];
   assign root      = res_ff[24:0];

endmodule

`default_nettype wire

// ===== rtl/core/sauvola_local_threshold_top.sv =====
// sauvola_local_threshold_top: sauvola binarization over integral images, sequencer and multiplier
// depends on sauvola_pkg, sauvola_ram, sauvola_iter
// load word: its position is split into row and column by the bit-serial divide of the shared unit
// query word: runs the 48-step variance divide and then the 24-step square root on the shared unit;
// a one-pixel window or a huge variance skips the divide
// one word at a time; a finished result may wait in the output register while the next is taken
// reset clears control, configuration and the load position; stores hold nothing until loaded
`default_nettype none

module sauvola_local_threshold_top #(
   parameter int MAX_ROWS = 128,
   parameter int MAX_COLS = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_pixel_value,
   input  wire logic [6:0]  req_query_row,
   input  wire logic [6:0]  req_query_col,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_binary_pixel,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);

   localparam int RA    = $clog2(MAX_ROWS);
   localparam int CA    = $clog2(MAX_COLS);
   localparam int AW    = RA + CA;
   localparam int DEPTH = 2 ** AW;
   localparam int DW    = sauvola_pkg::DIM_W;
   localparam int TW    = 2 * DW;

   // configuration
   logic [7:0]  rows_ff, cols_ff, range_ff;
   logic [6:0]  win_ff;
   logic [15:0] k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= sauvola_pkg::ROWS_RESET;
         cols_ff  <= sauvola_pkg::COLS_RESET;
         win_ff   <= sauvola_pkg::WIN_RESET;
         k_ff     <= sauvola_pkg::K_RESET;
         range_ff <= sauvola_pkg::RANGE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            sauvola_pkg::CSR_FRAME_ROWS:    rows_ff  <= csr_write_data[7:0];
            sauvola_pkg::CSR_FRAME_COLS:    cols_ff  <= csr_write_data[7:0];
            sauvola_pkg::CSR_WINDOW_WIDTH:  win_ff   <= csr_write_data[6:0];
            sauvola_pkg::CSR_K_Q16:         k_ff     <= csr_write_data;
            sauvola_pkg::CSR_DYNAMIC_RANGE: range_ff <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   logic [DW-1:0] rows_eff, cols_eff;
   logic [TW-1:0] total;
   logic [7:0]    r_eff;
   logic [5:0]    half;

   always_comb begin
      if (rows_ff == 8'd0) rows_eff = DW'(1);
      else if (DW'(rows_ff) > DW'(MAX_ROWS)) rows_eff = DW'(MAX_ROWS);
      else rows_eff = DW'(rows_ff);
      if (cols_ff == 8'd0) cols_eff = DW'(1);
      else if (DW'(cols_ff) > DW'(MAX_COLS)) cols_eff = DW'(MAX_COLS);
      else cols_eff = DW'(cols_ff);
      total = TW'(rows_eff) * TW'(cols_eff);
      r_eff = (range_ff == 8'd0) ? 8'd1 : range_ff;
      half  = win_ff[6:1];
   end

   // state
   sauvola_pkg::state_type state_ff, state_in;
   logic [2:0]    mstep_ff, mstep_in;
   logic [7:0]    pix_ff, pix_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [RA-1:0] lr_ff, lr_in;
   logic [CA-1:0] lc_ff, lc_in;
   logic [14:0]   row_ff, row_in;
   logic [22:0]   rowsq_ff, rowsq_in;
   logic [DW-1:0] qr_ff, qr_in, qc_ff, qc_in;
   logic [DW-1:0] r0_ff, r0_in, r1_ff, r1_in, c0_ff, c0_in, c1_ff, c1_in;
   logic          rd_pend_ff, rd_pend_in, rd_add_ff, rd_add_in, rd_zero_ff, rd_zero_in;
   logic [21:0]   s_ff, s_in;
   logic [29:0]   q_ff, q_in;
   logic [13:0]   area_ff, area_in;
   logic [43:0]   aq_ff, aq_in, ss_ff, ss_in, num_ff, num_in;
   logic [27:0]   d_ff, d_in;
   logic [47:0]   var_ff, var_in;
   logic [24:0]   std_ff, std_in, t1_ff, t1_in;
   logic [41:0]   f_ff, f_in;
   logic [21:0]   pa_ff, pa_in;
   logic [42:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic [29:0]   lhs_ff, lhs_in;
   logic [63:0]   rhs_ff, rhs_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_pix_ff, rsp_pix_in;
   logic [63:0]   mul_p_ff;
   logic [31:0]   mul_a, mul_b;

   // memories
   logic          st_wr_en, st_rd_en, px_rd_en;
   logic [AW-1:0] st_wr_addr, st_rd_addr, px_rd_addr;
   logic [21:0]   sum_wr_data, sum_rd_data;
   logic [29:0]   sq_wr_data, sq_rd_data;
   logic [7:0]    px_rd_data;

   sauvola_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_pixel_ram (
      .clock(clock), .wr_en(st_wr_en), .wr_addr(st_wr_addr), .wr_data(pix_ff),
      .rd_en(px_rd_en), .rd_addr(px_rd_addr), .rd_data(px_rd_data)
   );

   sauvola_ram #(.WIDTH(22), .DEPTH(DEPTH)) u_sum_ram (
      .clock(clock), .wr_en(st_wr_en), .wr_addr(st_wr_addr), .wr_data(sum_wr_data),
      .rd_en(st_rd_en), .rd_addr(st_rd_addr), .rd_data(sum_rd_data)
   );

   sauvola_ram #(.WIDTH(30), .DEPTH(DEPTH)) u_sq_ram (
      .clock(clock), .wr_en(st_wr_en), .wr_addr(st_wr_addr), .wr_data(sq_wr_data),
      .rd_en(st_rd_en), .rd_addr(st_rd_addr), .rd_data(sq_rd_data)
   );

   // shared divide / square root unit
   sauvola_pkg::iter_cmd_type iter_cmd;
   logic [27:0] iter_rem_init, iter_divisor, iter_rem;
   logic [47:0] iter_dividend, iter_quot;
   logic [24:0] iter_root;
   logic        iter_done;

   sauvola_iter u_iter (
      .clock(clock), .reset(reset), .cmd(iter_cmd),
      .rem_init(iter_rem_init), .dividend(iter_dividend), .divisor(iter_divisor),
      .radicand(var_ff), .done(iter_done), .quotient(iter_quot),
      .remainder(iter_rem), .root(iter_root)
   );

   logic          req_accept;
   logic [AW-1:0] pos_wrap, pos_next;
   logic [AW:0]   pos_inc;
   logic [DW-1:0] qr_ext, qc_ext, r1_try, c1_try, ri_sel, ci_sel, ri_m1, ci_m1;
   logic          ovf, big_area, lt;
   logic [14:0]   row_base;
   logic [22:0]   rowsq_base;
   logic [21:0]   up_sum, acc_s;
   logic [29:0]   up_sq, acc_q;

   assign req_stall  = (state_ff != sauvola_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      pos_wrap = (TW'(pos_ff) >= total) ? '0 : pos_ff;
      pos_inc  = {1'b0, pos_ff} + (AW+1)'(1);
      pos_next = (TW'(pos_inc) >= total) ? '0 : pos_inc[AW-1:0];
      qr_ext   = DW'(req_query_row);
      qc_ext   = DW'(req_query_col);
      r1_try   = qr_ff + DW'(half) + DW'(1);
      c1_try   = qc_ff + DW'(half) + DW'(1);
      case (mstep_ff[1:0])
         2'd0:    begin ri_sel = r1_ff; ci_sel = c1_ff; end
         2'd1:    begin ri_sel = r0_ff; ci_sel = c1_ff; end
         2'd2:    begin ri_sel = r1_ff; ci_sel = c0_ff; end
         default: begin ri_sel = r0_ff; ci_sel = c0_ff; end
      endcase
      ri_m1      = ri_sel - DW'(1);
      ci_m1      = ci_sel - DW'(1);
      ovf        = (num_ff >= {d_ff, 16'd0});
      big_area   = (area_ff > 14'd1);
      lt         = (64'({lhs_ff, 32'd0}) < rhs_ff);
      row_base   = (lc_ff == '0) ? 15'd0 : row_ff;
      rowsq_base = (lc_ff == '0) ? 23'd0 : rowsq_ff;
      up_sum     = (lr_ff == '0) ? 22'd0 : sum_rd_data;
      up_sq      = (lr_ff == '0) ? 30'd0 : sq_rd_data;
      acc_s      = rd_zero_ff ? 22'd0 : sum_rd_data;
      acc_q      = rd_zero_ff ? 30'd0 : sq_rd_data;
   end

   // memory ports
   always_comb begin
      st_wr_en    = (state_ff == sauvola_pkg::ST_L_WRITE);
      st_wr_addr  = {lr_ff, lc_ff};
      sum_wr_data = up_sum + 22'(row_in);
      sq_wr_data  = up_sq + 30'(rowsq_in);
      px_rd_en    = (state_ff == sauvola_pkg::ST_Q_BOUND);
      px_rd_addr  = {qr_ff[RA-1:0], qc_ff[CA-1:0]};
      if (state_ff == sauvola_pkg::ST_L_READ) begin
         st_rd_en   = (lr_ff != '0);
         st_rd_addr = {lr_ff - RA'(1), lc_ff};
      end else begin
         st_rd_en   = (state_ff == sauvola_pkg::ST_Q_READ);
         st_rd_addr = {ri_m1[RA-1:0], ci_m1[CA-1:0]};
      end
   end

   // shared unit commands
   always_comb begin
      iter_cmd.start = (req_accept && req_command == sauvola_pkg::CMD_LOAD)
                     || (state_ff == sauvola_pkg::ST_Q_OVF && big_area && !ovf)
                     || (state_ff == sauvola_pkg::ST_Q_SQS);
      iter_cmd.sqrt  = (state_ff == sauvola_pkg::ST_Q_SQS);
      if (state_ff == sauvola_pkg::ST_Q_SQS) iter_cmd.steps = sauvola_pkg::SQRT_STEPS;
      else if (state_ff == sauvola_pkg::ST_Q_OVF) iter_cmd.steps = sauvola_pkg::VAR_DIV_STEPS;
      else iter_cmd.steps = 6'(AW);
      if (state_ff == sauvola_pkg::ST_Q_OVF) begin
         iter_rem_init = num_ff[43:16];
         iter_dividend = {num_ff[15:0], 32'd0};
         iter_divisor  = d_ff;
      end else begin
         iter_rem_init = '0;
         iter_dividend = {pos_wrap, {(48-AW){1'b0}}};
         iter_divisor  = 28'(cols_eff);
      end
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         sauvola_pkg::ST_L_READ: begin
            mul_a = 32'(pix_ff);
            mul_b = 32'(pix_ff);
         end
         sauvola_pkg::ST_Q_MUL: begin
            case (mstep_ff)
               3'd0: begin mul_a = 32'(r1_ff - r0_ff); mul_b = 32'(c1_ff - c0_ff); end
               3'd1: begin mul_a = 32'(mul_p_ff[13:0]); mul_b = 32'(q_ff); end
               3'd2: begin mul_a = 32'(s_ff); mul_b = 32'(s_ff); end
               3'd3: begin mul_a = 32'(area_ff); mul_b = 32'(area_ff - 14'd1); end
               default: ;
            endcase
         end
         sauvola_pkg::ST_Q_FIN: begin
            case (mstep_ff)
               3'd0: begin mul_a = 32'(r_eff); mul_b = 32'(17'h10000 - {1'b0, k_ff}); end
               3'd1: begin mul_a = 32'(k_ff); mul_b = 32'(std_ff); end
               3'd2: begin mul_a = 32'(px_rd_data); mul_b = 32'(area_ff); end
               3'd3: begin mul_a = 32'(s_ff); mul_b = 32'(f_ff[20:0]); end
               3'd4: begin mul_a = 32'(s_ff); mul_b = 32'(f_ff[41:21]); end
               3'd5: begin mul_a = 32'(pa_ff); mul_b = 32'(r_eff); end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mstep_in     = mstep_ff;
      pix_in       = pix_ff;
      pos_in       = pos_ff;
      lr_in        = lr_ff;
      lc_in        = lc_ff;
      row_in       = row_ff;
      rowsq_in     = rowsq_ff;
      qr_in        = qr_ff;
      qc_in        = qc_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      c0_in        = c0_ff;
      c1_in        = c1_ff;
      rd_pend_in   = 1'b0;
      rd_add_in    = rd_add_ff;
      rd_zero_in   = rd_zero_ff;
      s_in         = s_ff;
      q_in         = q_ff;
      area_in      = area_ff;
      aq_in        = aq_ff;
      ss_in        = ss_ff;
      d_in         = d_ff;
      num_in       = num_ff;
      var_in       = var_ff;
      std_in       = std_ff;
      t1_in        = t1_ff;
      f_in         = f_ff;
      pa_in        = pa_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      lhs_in       = lhs_ff;
      rhs_in       = rhs_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pix_in   = rsp_pix_ff;

      if (rd_pend_ff) begin
         s_in = rd_add_ff ? (s_ff + acc_s) : (s_ff - acc_s);
         q_in = rd_add_ff ? (q_ff + acc_q) : (q_ff - acc_q);
      end

      case (state_ff)
         sauvola_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_command == sauvola_pkg::CMD_LOAD) begin
                  pix_in   = req_pixel_value;
                  pos_in   = pos_wrap;
                  state_in = sauvola_pkg::ST_L_DIV;
               end else begin
                  qr_in    = (qr_ext > rows_eff - DW'(1)) ? rows_eff - DW'(1) : qr_ext;
                  qc_in    = (qc_ext > cols_eff - DW'(1)) ? cols_eff - DW'(1) : qc_ext;
                  state_in = sauvola_pkg::ST_Q_BOUND;
               end
            end
         end
         sauvola_pkg::ST_L_DIV: begin
            if (iter_done) begin
               lr_in    = iter_quot[RA-1:0];
               lc_in    = iter_rem[CA-1:0];
               state_in = sauvola_pkg::ST_L_READ;
            end
         end
         sauvola_pkg::ST_L_READ: begin
            state_in = sauvola_pkg::ST_L_WRITE;
         end
         sauvola_pkg::ST_L_WRITE: begin
            row_in   = row_base + 15'(pix_ff);
            rowsq_in = rowsq_base + 23'(mul_p_ff[15:0]);
            pos_in   = pos_next;
            state_in = sauvola_pkg::ST_IDLE;
         end
         sauvola_pkg::ST_Q_BOUND: begin
            r0_in    = (qr_ff > DW'(half)) ? qr_ff - DW'(half) : '0;
            c0_in    = (qc_ff > DW'(half)) ? qc_ff - DW'(half) : '0;
            r1_in    = (r1_try > rows_eff) ? rows_eff : r1_try;
            c1_in    = (c1_try > cols_eff) ? cols_eff : c1_try;
            s_in     = '0;
            q_in     = '0;
            mstep_in = '0;
            state_in = sauvola_pkg::ST_Q_READ;
         end
         sauvola_pkg::ST_Q_READ: begin
            rd_pend_in = 1'b1;
            rd_add_in  = (mstep_ff[1:0] == 2'd0) || (mstep_ff[1:0] == 2'd3);
            rd_zero_in = (ri_sel == '0) || (ci_sel == '0);
            mstep_in   = mstep_ff + 3'd1;
            if (mstep_ff[1:0] == 2'd3) begin
               state_in = sauvola_pkg::ST_Q_ACC;
            end
         end
         sauvola_pkg::ST_Q_ACC: begin
            mstep_in = '0;
            state_in = sauvola_pkg::ST_Q_MUL;
         end
         sauvola_pkg::ST_Q_MUL: begin
            mstep_in = mstep_ff + 3'd1;
            case (mstep_ff)
               3'd1: area_in = mul_p_ff[13:0];
               3'd2: aq_in   = mul_p_ff[43:0];
               3'd3: ss_in   = mul_p_ff[43:0];
               3'd4: begin
                  d_in     = mul_p_ff[27:0];
                  state_in = sauvola_pkg::ST_Q_NUM;
               end
               default: ;
            endcase
         end
         sauvola_pkg::ST_Q_NUM: begin
            num_in   = (aq_ff > ss_ff) ? aq_ff - ss_ff : '0;
            state_in = sauvola_pkg::ST_Q_OVF;
         end
         sauvola_pkg::ST_Q_OVF: begin
            if (!big_area) begin
               var_in   = '0;
               state_in = sauvola_pkg::ST_Q_SQS;
            end else if (ovf) begin
               var_in   = sauvola_pkg::VAR_MAX;
               state_in = sauvola_pkg::ST_Q_SQS;
            end else begin
               state_in = sauvola_pkg::ST_Q_DIV;
            end
         end
         sauvola_pkg::ST_Q_DIV: begin
            if (iter_done) begin
               var_in   = iter_quot;
               state_in = sauvola_pkg::ST_Q_SQS;
            end
         end
         sauvola_pkg::ST_Q_SQS: begin
            state_in = sauvola_pkg::ST_Q_SQRT;
         end
         sauvola_pkg::ST_Q_SQRT: begin
            if (iter_done) begin
               std_in   = iter_root;
               mstep_in = '0;
               state_in = sauvola_pkg::ST_Q_FIN;
            end
         end
         sauvola_pkg::ST_Q_FIN: begin
            mstep_in = mstep_ff + 3'd1;
            case (mstep_ff)
               3'd1: t1_in = mul_p_ff[24:0];
               3'd2: f_in  = {t1_ff, 16'd0} + 42'(mul_p_ff[40:0]);
               3'd3: pa_in = mul_p_ff[21:0];
               3'd4: lo_in = mul_p_ff[42:0];
               3'd5: hi_in = mul_p_ff[42:0];
               3'd6: begin
                  lhs_in   = mul_p_ff[29:0];
                  rhs_in   = 64'(lo_ff) + (64'(hi_ff) << 21);
                  state_in = sauvola_pkg::ST_Q_CMP;
               end
               default: ;
            endcase
         end
         sauvola_pkg::ST_Q_CMP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = lt ? sauvola_pkg::PIX_BLACK : sauvola_pkg::PIX_WHITE;
               state_in     = sauvola_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sauvola_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sauvola_pkg::ST_IDLE;
         mstep_ff     <= '0;
         pos_ff       <= '0;
         row_ff       <= '0;
         rowsq_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mstep_ff     <= mstep_in;
         pos_ff       <= pos_in;
         row_ff       <= row_in;
         rowsq_ff     <= rowsq_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pix_ff     <= pix_in;
      lr_ff      <= lr_in;
      lc_ff      <= lc_in;
      qr_ff      <= qr_in;
      qc_ff      <= qc_in;
      r0_ff      <= r0_in;
      r1_ff      <= r1_in;
      c0_ff      <= c0_in;
      c1_ff      <= c1_in;
      rd_add_ff  <= rd_add_in;
      rd_zero_ff <= rd_zero_in;
      s_ff       <= s_in;
      q_ff       <= q_in;
      area_ff    <= area_in;
      aq_ff      <= aq_in;
      ss_ff      <= ss_in;
      d_ff       <= d_in;
      num_ff     <= num_in;
      var_ff     <= var_in;
      std_ff     <= std_in;
      t1_ff      <= t1_in;
      f_ff       <= f_in;
      pa_ff      <= pa_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      lhs_ff     <= lhs_in;
      rhs_ff     <= rhs_in;
      rsp_pix_ff <= rsp_pix_in;
      mul_p_ff   <= mul_a * mul_b;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_binary_pixel = rsp_pix_ff;

   // shared unit finishes only where the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      iter_done |-> (state_ff == sauvola_pkg::ST_L_DIV || state_ff == sauvola_pkg::ST_Q_DIV
                     || state_ff == sauvola_pkg::ST_Q_SQRT))
      else $error("shared unit finished outside a wait state");

   // load position split gives a column inside the frame
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sauvola_pkg::ST_L_DIV && iter_done) |-> (iter_rem < 28'(cols_eff)))
      else $error("load column out of frame");

   // a new result word only comes from the compare step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == sauvola_pkg::ST_Q_CMP))
      else $error("result word raised outside compare step");

endmodule

`default_nettype wire

// ===== tb/sv/sauvola_checker.sv =====
// sauvola_checker: watches the request, result and register ports of the sauvola block,
// predicts each binary pixel from its own integral images and compares in order
// depends on sauvola_pkg
`timescale 1ns / 1ps
`default_nettype none

module sauvola_checker
   import sauvola_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_pixel_value,
   input  wire logic [6:0]  req_query_row,
   input  wire logic [6:0]  req_query_col,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [7:0]  rsp_binary_pixel,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_write_data,
   output int               failures,
   output int               outstanding,
   output int               loads_seen,
   output int               queries_seen,
   output int               black_seen
);

   localparam int NCOL = 128;
   localparam int NPIX = 128 * 128;

   logic [7:0]  rows_cfg, cols_cfg, range_cfg;
   logic [6:0]  width_cfg;
   logic [15:0] k_cfg;

   logic [7:0]  pixel_mem [NPIX];
   logic [21:0] sum_mem [NPIX];
   logic [29:0] square_mem [NPIX];
   logic [14:0] row_sum;
   logic [22:0] row_square;
   int unsigned load_pos;

   logic [7:0] binary_queue [$];

   function automatic int unsigned rows_used();
      if (rows_cfg == 0) return 1;
      return (rows_cfg > 128) ? 128 : rows_cfg;
   endfunction

   function automatic int unsigned cols_used();
      if (cols_cfg == 0) return 1;
      return (cols_cfg > 128) ? 128 : cols_cfg;
   endfunction

   function automatic logic [21:0] sum_at(int unsigned r1, int unsigned c1);
      if (r1 == 0 || c1 == 0) return '0;
      return sum_mem[(r1 - 1) * NCOL + (c1 - 1)];
   endfunction

   function automatic logic [29:0] square_at(int unsigned r1, int unsigned c1);
      if (r1 == 0 || c1 == 0) return '0;
      return square_mem[(r1 - 1) * NCOL + (c1 - 1)];
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic logic [7:0] predict_binary(logic [6:0] row, logic [6:0] col);
      int unsigned rows, cols, qr, qc, half, r0, c0, r1, c1;
      logic [21:0] s22;
      logic [29:0] q30;
      longint unsigned area, s, q, aq, ss, num, d, ip, rem, var_q32, std_q16;
      longint unsigned rng, kk, f, lhs, rhs, pix;
      rows = rows_used();
      cols = cols_used();
      qr = (row > rows - 1) ? rows - 1 : row;
      qc = (col > cols - 1) ? cols - 1 : col;
      half = width_cfg >> 1;
      r0 = (qr > half) ? qr - half : 0;
      c0 = (qc > half) ? qc - half : 0;
      r1 = (qr + half + 1 > rows) ? rows : qr + half + 1;
      c1 = (qc + half + 1 > cols) ? cols : qc + half + 1;
      area = longint'(r1 - r0) * longint'(c1 - c0);
      s22 = sum_at(r1, c1) - sum_at(r0, c1) - sum_at(r1, c0) + sum_at(r0, c0);
      q30 = square_at(r1, c1) - square_at(r0, c1) - square_at(r1, c0) + square_at(r0, c0);
      s = s22;
      q = q30;
      var_q32 = 0;
      if (area > 1) begin
         aq = area * q;
         ss = s * s;
         num = (aq > ss) ? aq - ss : 0;
         d = area * (area - 1);
         ip = num / d;
         rem = num % d;
         if (ip >= 65536) var_q32 = (64'd1 << 48) - 1;
         else var_q32 = (ip << 32) + (rem << 32) / d;
      end
      std_q16 = int_sqrt(var_q32);
      rng = (range_cfg == 0) ? 1 : range_cfg;
      kk = k_cfg;
      f = rng * 65536 * (65536 - kk) + kk * std_q16;
      pix = pixel_mem[qr * NCOL + qc];
      lhs = (pix * area * rng) << 32;
      rhs = s * f;
      return (lhs < rhs) ? PIX_BLACK : PIX_WHITE;
   endfunction

   task automatic store_pixel(logic [7:0] p);
      int unsigned total, r, c, idx;
      logic [21:0] up;
      logic [29:0] upq;
      total = rows_used() * cols_used();
      if (load_pos >= total) load_pos = 0;
      r = load_pos / cols_used();
      c = load_pos % cols_used();
      idx = r * NCOL + c;
      if (c == 0) begin
         row_sum = '0;
         row_square = '0;
      end
      row_sum = row_sum + p;
      row_square = row_square + 23'(p) * 23'(p);
      up = r ? sum_mem[idx - NCOL] : '0;
      upq = r ? square_mem[idx - NCOL] : '0;
      pixel_mem[idx] = p;
      sum_mem[idx] = up + 22'(row_sum);
      square_mem[idx] = upq + 30'(row_square);
      load_pos++;
      if (load_pos >= total) load_pos = 0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rows_cfg = ROWS_RESET;
         cols_cfg = COLS_RESET;
         width_cfg = WIN_RESET;
         k_cfg = K_RESET;
         range_cfg = RANGE_RESET;
         row_sum = '0;
         row_square = '0;
         load_pos = 0;
         binary_queue.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FRAME_ROWS:    rows_cfg = csr_write_data[7:0];
               CSR_FRAME_COLS:    cols_cfg = csr_write_data[7:0];
               CSR_WINDOW_WIDTH:  width_cfg = csr_write_data[6:0];
               CSR_K_Q16:         k_cfg = csr_write_data;
               CSR_DYNAMIC_RANGE: range_cfg = csr_write_data[7:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_command == CMD_LOAD) begin
               store_pixel(req_pixel_value);
               loads_seen++;
            end else begin
               binary_queue.push_back(predict_binary(req_query_row, req_query_col));
               queries_seen++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (binary_queue.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual %0d",
                        $time, rsp_binary_pixel);
               failures++;
            end else begin
               if (rsp_binary_pixel !== binary_queue[0]) begin
                  $display("%0t: binary_pixel mismatch, expected %0d, actual %0d",
                           $time, binary_queue[0], rsp_binary_pixel);
                  failures++;
               end
               if (binary_queue[0] == PIX_BLACK) black_seen++;
               void'(binary_queue.pop_front());
            end
         end
      end
      outstanding = binary_queue.size();
   end

   initial begin
      failures = 0;
      outstanding = 0;
      loads_seen = 0;
      queries_seen = 0;
      black_seen = 0;
   end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench: drives load and query words and register settings into the sauvola block
// in phases of frame size, window, k and range; the checker judges every result
// depends on sauvola_pkg, sauvola_local_threshold_top, sauvola_checker
`timescale 1ns / 1ps
`default_nettype none

module testbench;
   import sauvola_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_command;
   logic [7:0]  req_pixel_value;
   logic [6:0]  req_query_row;
   logic [6:0]  req_query_col;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_binary_pixel;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [15:0] csr_write_data;

   int failures, outstanding, loads_seen, queries_seen, black_seen;
   int burst_left;

   typedef struct {
      int rows;
      int cols;
      int width;
      int k;
      int range;
      int extra;
   } phase_type;

   phase_type phases [9] = '{
      '{4, 4, 3, 22282, 128, 0},
      '{2, 2, 127, 0, 1, 50},
      '{128, 2, 51, 65535, 255, 30},
      '{2, 64, 5, 32768, 0, 35},
      '{0, 200, 1, 22282, 128, 35},
      '{8, 8, 0, 13107, 64, 40},
      '{9, 13, 7, 45000, 200, 35},
      '{6, 10, 31, 22282, 128, 40},
      '{255, 1, 15, 54321, 85, 35}
   };

   sauvola_local_threshold_top dut (.*);

   sauvola_checker checker_inst (.*);

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

   // receiver: changing stall density, with a long hold while results are pending
   initial begin
      int cycle_count, mode, mode_left, next_hold;
      cycle_count = 0;
      mode = 0;
      mode_left = 0;
      next_hold = 3000;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (req_valid && outstanding != 0 && cycle_count >= next_hold) begin
            rsp_stall <= 1'b1;
            repeat (600) @(posedge clock);
            cycle_count += 600;
            next_hold = cycle_count + 12000;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   task automatic send_word(logic cmd, logic [7:0] pix, logic [6:0] row, logic [6:0] col);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_pixel_value <= pix;
      req_query_row <= row;
      req_query_col <= col;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, int value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= 16'(value);
      @(posedge clock);
   endtask

   function automatic logic [7:0] random_pixel(int style);
      if (style == 0) return 8'($urandom);
      if (style == 1) return ($urandom_range(0, 1) ? 8'($urandom_range(200, 255))
                                                    : 8'($urandom_range(0, 50)));
      return 8'($urandom_range(100, 140));
   endfunction

   initial begin
      int total, style, extra_loads;
      logic [6:0] row, col;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_LOAD;
      req_pixel_value = '0;
      req_query_row = '0;
      req_query_col = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      burst_left = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (phases[i]) begin
         write_reg(CSR_FRAME_ROWS, phases[i].rows);
         write_reg(CSR_FRAME_COLS, phases[i].cols);
         write_reg(CSR_WINDOW_WIDTH, phases[i].width);
         write_reg(CSR_K_Q16, phases[i].k);
         write_reg(CSR_DYNAMIC_RANGE, phases[i].range);
         csr_write_enable <= 1'b0;
         @(posedge clock);
         total = ((phases[i].rows == 0) ? 1 : (phases[i].rows > 128 ? 128 : phases[i].rows))
               * ((phases[i].cols == 0) ? 1 : (phases[i].cols > 128 ? 128 : phases[i].cols));
         style = $urandom_range(0, 2);
         extra_loads = 0;
         if (i == 0) begin
            // corners of the gray scale, then corners and outside of the frame
            for (int n = 0; n < total; n++)
               send_word(CMD_LOAD, (n % 3 == 0) ? 8'd0 : ((n % 3 == 1) ? 8'd255 : 8'(n * 17)),
                         7'($urandom), 7'($urandom));
            send_word(CMD_QUERY, 8'($urandom), 7'd0, 7'd0);
            send_word(CMD_QUERY, 8'($urandom), 7'd3, 7'd3);
            send_word(CMD_QUERY, 8'($urandom), 7'd127, 7'd127);
            send_word(CMD_QUERY, 8'($urandom), 7'd127, 7'd0);
            send_word(CMD_QUERY, 8'($urandom), 7'd0, 7'd127);
            send_word(CMD_QUERY, 8'($urandom), 7'd1, 7'd2);
            send_word(CMD_QUERY, 8'($urandom), 7'd2, 7'd1);
            for (int n = 0; n < 16; n++)
               send_word(CMD_QUERY, 8'($urandom), 7'(n / 4), 7'(n % 4));
         end else begin
            for (int n = 0; n < total; n++)
               send_word(CMD_LOAD, random_pixel(style), 7'($urandom), 7'($urandom));
            for (int n = 0; n < phases[i].extra; n++) begin
               if (total <= 64 && $urandom_range(0, 9) < 4) begin
                  send_word(CMD_LOAD, random_pixel(style), 7'($urandom), 7'($urandom));
                  extra_loads++;
               end else begin
                  row = ($urandom_range(0, 7) == 0) ? 7'($urandom)
                        : 7'($urandom_range(0, phases[i].rows > 1 ? phases[i].rows - 1 : 0));
                  col = ($urandom_range(0, 7) == 0) ? 7'($urandom)
                        : 7'($urandom_range(0, phases[i].cols > 1 ? phases[i].cols - 1 : 0));
                  send_word(CMD_QUERY, 8'($urandom), row, col);
               end
            end
            // finish the frame so the next one starts at the first pixel
            while (extra_loads % total != 0) begin
               send_word(CMD_LOAD, random_pixel(style), 7'($urandom), 7'($urandom));
               extra_loads++;
            end
         end
         drain();
      end
      repeat (150) @(posedge clock);
      $display("covered %0d load words and %0d query words over %0d register settings",
               loads_seen, queries_seen, $size(phases));
      $display("%0d results were black, %0d white", black_seen, queries_seen - black_seen);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
